[design/mqlf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mqlf_pkg;

	// default sizes of the shared link table
	localparam int DEF_NUM_ITEMS   = 64;
	localparam int DEF_NUM_QUEUES  = 8;
	localparam int DEF_TABLE_DEPTH = 80;

	// fixed field widths
	localparam int REQ_W   = 2;
	localparam int ITEM_W  = 6;
	localparam int QUEUE_W = 3;
	localparam int QIU_W   = 4;

	localparam logic [QIU_W-1:0] QIU_RESET = 4'd8;

	// request codes
	localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE  = 2'd2;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_EMPTY      = 3'd1,
		ST_BAD_QUEUE  = 3'd2,
		ST_BAD_ITEM   = 3'd3,
		ST_NOT_QUEUED = 3'd4
	} status_t;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [ITEM_W-1:0]  item_id;
		logic [QUEUE_W-1:0] queue_id;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ITEM_W-1:0] item_id_out;
	} rsp_t;

	// link table read selection
	typedef enum logic [1:0] {
		RD_NONE,
		RD_REQ,
		RD_FIRST
	} rd_op_t;

	// link table write selection
	typedef enum logic [2:0] {
		WR_NONE,
		WR_INIT,
		WR_ENQ_NODE,
		WR_ENQ_LINK,
		WR_UNLINK
	} wr_op_t;

	typedef struct packed {
		logic    load;
		logic    sweep;
		rd_op_t  rd;
		wr_op_t  wr;
		logic    finish;
		status_t status;
	} ctrl_cmd_t;

	typedef struct packed {
		logic             sweep_last;
		logic [REQ_W-1:0] req_type;
		logic             queue_ok;
		logic             item_ok;
		logic             queued;
		logic             first_bad;
	} dp_stat_t;

endpackage
`default_nettype wire

[design/multi_queue_linked_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// Several FIFO queues sharing one doubly linked table of item nodes.
// Request channel: req (type, item, queue) is taken at a clock edge with
// start high and busy low. Types: enqueue at a queue's tail, dequeue a
// queue's head, remove a named item from whatever queue holds it.
// Result channel: done is high for exactly one cycle with result (status
// and item); every request gives one result and the receiver cannot stall.
// The request then passes through READ and EVAL; a rejected request or a
// remove finishes in EVAL, enqueue goes on to LINK and dequeue to UNLINK.
// busy drops in the result cycle, so a new request can follow at once.
// The steps are set by the single write port of each link memory
// and the registered read of the link table (read, check, write).
// Config channel: cfg_data sets the number of valid queues, taken when
// cfg_valid and cfg_ready are high; cfg_ready is always high. Write it
// only while the block is idle.
// Reset: after arst_n releases, an init sweep over max(NUM_ITEMS,
// NUM_QUEUES) entries links each queue's head to its tail and clears the
// queued flags; busy is high during it. The queue limit resets to 8.
module multi_queue_linked_fifo import mqlf_pkg::*; #(
	parameter int NUM_ITEMS   = DEF_NUM_ITEMS,
	parameter int NUM_QUEUES  = DEF_NUM_QUEUES,
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire req_t             req,
	output logic                  done,
	output rsp_t                  result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [QIU_W-1:0] cfg_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	assign cfg_ready = 1'b1;

	// sequencer
	mqlf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// link table and checks
	mqlf_dp #(
		.NUM_ITEMS   (NUM_ITEMS),
		.NUM_QUEUES  (NUM_QUEUES),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.result   (result)
	);

	// a result only follows a cycle of work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// strobes never run back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held two cycles");

	// accepted request makes the block busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// failed requests carry no item
	a_fail_zero_item: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != ST_OK)) |-> (result.item_id_out == '0))
		else $error("item reported on a failed request");

endmodule
`default_nettype wire

[design/mqlf_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module mqlf_dp import mqlf_pkg::*; #(
	parameter int NUM_ITEMS   = DEF_NUM_ITEMS,
	parameter int NUM_QUEUES  = DEF_NUM_QUEUES,
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire req_t             req,
	input  wire logic             cfg_we,
	input  wire logic [QIU_W-1:0] cfg_data,
	input  wire ctrl_cmd_t        cmd,
	output dp_stat_t              stat,
	output rsp_t                  result
);

	localparam int TW        = $clog2(TABLE_DEPTH);
	localparam int IW        = $clog2(NUM_ITEMS);
	localparam int NW        = (TW > ITEM_W) ? TW : ITEM_W;
	localparam int SWEEP_LEN = (NUM_ITEMS > NUM_QUEUES) ? NUM_ITEMS : NUM_QUEUES;
	localparam int CW        = $clog2(SWEEP_LEN);

	// link memories and queued flags
	logic [TW-1:0] next_mem [TABLE_DEPTH];
	logic [TW-1:0] prev_mem [TABLE_DEPTH];
	logic          queued_mem [NUM_ITEMS];

	logic [QIU_W-1:0]   qiu_q;
	logic [CW-1:0]      sweep_cnt_q;
	logic [REQ_W-1:0]   req_type_q;
	logic [ITEM_W-1:0]  item_q;
	logic [QUEUE_W-1:0] queue_q;
	logic [NW-1:0]      node_q;
	logic [TW-1:0]      rd_next_q;
	logic [TW-1:0]      rd_prev_q;
	logic               rd_queued_q;
	rsp_t               result_q;

	logic [31:0]   head_w;
	logic [31:0]   tail_w;
	logic [31:0]   init_head_w;
	logic          init_fit;
	logic [TW-1:0] node_a;
	logic [IW-1:0] node_i;

	logic          nx_we, pv_we, qd_we, rd_en;
	logic [TW-1:0] nx_wa, nx_wd, pv_wa, pv_wd, nx_ra, pv_ra;
	logic [IW-1:0] qd_wa, qd_ra;
	logic          qd_wd;

	// sentinel addresses of the request queue and of the sweep queue
	assign head_w      = 32'(NUM_ITEMS) + {{(31-QUEUE_W){1'b0}}, queue_q, 1'b0};
	assign tail_w      = head_w + 32'd1;
	assign init_head_w = 32'(NUM_ITEMS) + {{(31-CW){1'b0}}, sweep_cnt_q, 1'b0};
	assign init_fit    = (32'(sweep_cnt_q) < 32'(NUM_QUEUES))
		&& (init_head_w + 32'd1 < 32'(TABLE_DEPTH));
	assign node_a      = TW'(node_q);
	assign node_i      = IW'(node_q);

	// checks handed to the controller
	always_comb begin
		stat.sweep_last = (sweep_cnt_q == CW'(SWEEP_LEN - 1));
		stat.req_type   = req_type_q;
		stat.queue_ok   = ({1'b0, queue_q} < qiu_q)
			&& (32'(queue_q) < 32'(NUM_QUEUES))
			&& (tail_w < 32'(TABLE_DEPTH));
		stat.item_ok    = (32'(item_q) < 32'(NUM_ITEMS))
			&& (32'(item_q) < 32'(TABLE_DEPTH));
		stat.queued     = rd_queued_q;
		stat.first_bad  = (32'(rd_next_q) == tail_w)
			|| !((32'(rd_next_q) < 32'(NUM_ITEMS))
			&& (32'(rd_next_q) < 32'(TABLE_DEPTH)));
	end

	// read port addresses
	always_comb begin
		rd_en = 1'b0;
		nx_ra = '0;
		pv_ra = '0;
		qd_ra = IW'(item_q);
		case (cmd.rd)
			RD_REQ: begin
				rd_en = 1'b1;
				nx_ra = (req_type_q == REQ_DEQUEUE) ? TW'(head_w) : TW'(item_q);
				pv_ra = (req_type_q == REQ_ENQUEUE) ? TW'(tail_w) : TW'(item_q);
			end
			RD_FIRST: begin
				rd_en = 1'b1;
				nx_ra = rd_next_q;
				pv_ra = rd_next_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// write port selection
	always_comb begin
		nx_we = 1'b0;
		nx_wa = '0;
		nx_wd = '0;
		pv_we = 1'b0;
		pv_wa = '0;
		pv_wd = '0;
		qd_we = 1'b0;
		qd_wa = '0;
		qd_wd = 1'b0;
		case (cmd.wr)
			WR_INIT: begin
				nx_we = init_fit;
				nx_wa = TW'(init_head_w);
				nx_wd = TW'(init_head_w + 32'd1);
				pv_we = init_fit;
				pv_wa = TW'(init_head_w + 32'd1);
				pv_wd = TW'(init_head_w);
				qd_we = (32'(sweep_cnt_q) < 32'(NUM_ITEMS));
				qd_wa = IW'(sweep_cnt_q);
				qd_wd = 1'b0;
			end
			WR_ENQ_NODE: begin
				nx_we = 1'b1;
				nx_wa = node_a;
				nx_wd = TW'(tail_w);
				pv_we = 1'b1;
				pv_wa = node_a;
				pv_wd = rd_prev_q;
				qd_we = 1'b1;
				qd_wa = node_i;
				qd_wd = 1'b1;
			end
			WR_ENQ_LINK: begin
				nx_we = 1'b1;
				nx_wa = rd_prev_q;
				nx_wd = node_a;
				pv_we = 1'b1;
				pv_wa = TW'(tail_w);
				pv_wd = node_a;
			end
			WR_UNLINK: begin
				nx_we = 1'b1;
				nx_wa = rd_prev_q;
				nx_wd = rd_next_q;
				pv_we = 1'b1;
				pv_wa = rd_next_q;
				pv_wd = rd_prev_q;
				qd_we = 1'b1;
				qd_wa = node_i;
				qd_wd = 1'b0;
			end
			default: begin
				nx_we = 1'b0;
			end
		endcase
	end

	// memories with registered read data
	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_wa] <= nx_wd;
		end
		if (pv_we) begin
			prev_mem[pv_wa] <= pv_wd;
		end
		if (qd_we) begin
			queued_mem[qd_wa] <= qd_wd;
		end
		if (rd_en) begin
			rd_next_q   <= next_mem[nx_ra];
			rd_prev_q   <= prev_mem[pv_ra];
			rd_queued_q <= queued_mem[qd_ra];
		end
	end

	// control registers: queue limit and init sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qiu_q       <= QIU_RESET;
			sweep_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				qiu_q <= cfg_data;
			end
			if (cmd.sweep) begin
				sweep_cnt_q <= sweep_cnt_q + CW'(1);
			end
		end
	end

	// request and result holding
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req.req_type;
			item_q     <= req.item_id;
			queue_q    <= req.queue_id;
			node_q     <= NW'(req.item_id);
		end else if (cmd.rd == RD_FIRST) begin
			node_q <= NW'(rd_next_q);
		end
		if (cmd.finish) begin
			result_q.status      <= cmd.status;
			result_q.item_id_out <= (cmd.status == ST_OK) ? ITEM_W'(node_q) : '0;
		end
	end

	assign result = result_q;

endmodule
`default_nettype wire

[design/mqlf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module mqlf_ctrl import mqlf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire dp_stat_t stat,
	output ctrl_cmd_t     cmd,
	output logic          busy,
	output logic          done
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_UNLINK,
		S_LINK
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	// next state and datapath commands
	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.sweep  = 1'b0;
		cmd.rd     = RD_NONE;
		cmd.wr     = WR_NONE;
		cmd.finish = 1'b0;
		cmd.status = ST_OK;
		case (state_q)
			S_INIT: begin
				cmd.sweep = 1'b1;
				cmd.wr    = WR_INIT;
				if (stat.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_READ;
				end
			end
			S_READ: begin
				cmd.rd  = RD_REQ;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				state_d    = S_IDLE;
				cmd.finish = 1'b1;
				case (stat.req_type)
					REQ_ENQUEUE: begin
						if (!stat.queue_ok) begin
							cmd.status = ST_BAD_QUEUE;
						end else if (!stat.item_ok || stat.queued) begin
							cmd.status = ST_BAD_ITEM;
						end else begin
							cmd.finish = 1'b0;
							cmd.wr     = WR_ENQ_NODE;
							state_d    = S_LINK;
						end
					end
					REQ_DEQUEUE: begin
						if (!stat.queue_ok) begin
							cmd.status = ST_BAD_QUEUE;
						end else if (stat.first_bad) begin
							cmd.status = ST_EMPTY;
						end else begin
							cmd.finish = 1'b0;
							cmd.rd     = RD_FIRST;
							state_d    = S_UNLINK;
						end
					end
					REQ_REMOVE: begin
						if (!stat.item_ok) begin
							cmd.status = ST_BAD_ITEM;
						end else if (!stat.queued) begin
							cmd.status = ST_NOT_QUEUED;
						end else begin
							cmd.wr = WR_UNLINK;
						end
					end
					default: begin
						cmd.status = ST_BAD_QUEUE;
					end
				endcase
			end
			S_UNLINK: begin
				cmd.wr     = WR_UNLINK;
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			S_LINK: begin
				cmd.wr     = WR_ENQ_LINK;
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule
`default_nettype wire

[tb/sv/tb_multi_queue_linked_fifo.sv]
`timescale 1ns / 1ps
module tb_multi_queue_linked_fifo;
	import mqlf_pkg::*;

	localparam int NI        = DEF_NUM_ITEMS;
	localparam int NQ        = DEF_NUM_QUEUES;
	localparam int DEPTH     = DEF_TABLE_DEPTH;
	localparam int LINK_W    = $clog2(DEF_TABLE_DEPTH);
	localparam int PHASE_LEN = 170;
	localparam int SETTLE    = 8;
	localparam int LIMIT     = 200000;

	// request code the block does not define
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef enum logic {
		ROW_REQ,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		req_t              rq;
		logic [QIU_W-1:0]  cfg;
		logic              fixed;
		rsp_t              rsp;
	} dir_row_t;

	localparam req_t NO_REQ = '0;
	localparam rsp_t NO_RSP = '{ST_OK, 6'd0};

	// directed steps: fixed rows carry the response typed in
	localparam dir_row_t DIRECTED [27] = '{
		'{ROW_REQ, '{REQ_DEQUEUE, 6'd0, 3'd0}, 4'd0, 1'b1, '{ST_EMPTY, 6'd0}},
		'{ROW_REQ, '{REQ_REMOVE, 6'd0, 3'd0}, 4'd0, 1'b1, '{ST_NOT_QUEUED, 6'd0}},
		'{ROW_REQ, '{REQ_ENQUEUE, 6'd0, 3'd0}, 4'd0, 1'b1, '{ST_OK, 6'd0}},
		'{ROW_REQ, '{REQ_ENQUEUE, 6'd63, 3'd7}, 4'd0, 1'b1, '{ST_OK, 6'd63}},
		'{ROW_REQ, '{REQ_ENQUEUE, 6'd0, 3'd1}, 4'd0, 1'b1, '{ST_BAD_ITEM, 6'd0}},
		'{ROW_REQ, '{REQ_ENQUEUE, 6'd5, 3'd0}, 4'd0, 1'b0, NO_RSP},
		'{ROW_REQ, '{REQ_ENQUEUE, 6'd42, 3'd0}, 4'd0, 1'b0, NO_RSP},
		'{ROW_REQ, '{REQ_REMOVE, 6'd5, 3'd6}, 4'd0, 1'b0, NO_RSP},
		'{ROW_REQ, '{REQ_DEQUEUE, 6'd63, 3'd0}, 4'd0, 1'b1, '{ST_OK, 6'd0}},
		'{ROW_REQ, '{REQ_DEQUEUE, 6'd0, 3'd0}, 4'd0, 1'b0, NO_RSP},
		'{ROW_REQ, '{REQ_DEQUEUE, 6'd0, 3'd0}, 4'd0, 1'b1, '{ST_EMPTY, 6'd0}},
		'{ROW_REQ, '{REQ_UNUSED, 6'd63, 3'd7}, 4'd0, 1'b1, '{ST_BAD_QUEUE, 6'd0}},
		'{ROW_REQ, '{REQ_REMOVE, 6'd63, 3'd0}, 4'd0, 1'b0, NO_RSP},
		'{ROW_REQ, '{REQ_ENQUEUE, 6'd21, 3'd3}, 4'd0, 1'b0, NO_RSP},
		'{ROW_REQ, '{REQ_ENQUEUE, 6'd42, 3'd3}, 4'd0, 1'b0, NO_RSP},
		'{ROW_REQ, '{REQ_REMOVE, 6'd42, 3'd7}, 4'd0, 1'b0, NO_RSP},
		'{ROW_CFG, NO_REQ, 4'd1, 1'b0, NO_RSP},
		'{ROW_REQ, '{REQ_ENQUEUE, 6'd21, 3'd1}, 4'd0, 1'b1, '{ST_BAD_QUEUE, 6'd0}},
		'{ROW_REQ, '{REQ_DEQUEUE, 6'd0, 3'd7}, 4'd0, 1'b1, '{ST_BAD_QUEUE, 6'd0}},
		'{ROW_REQ, '{REQ_ENQUEUE, 6'd7, 3'd0}, 4'd0, 1'b0, NO_RSP},
		'{ROW_CFG, NO_REQ, 4'd0, 1'b0, NO_RSP},
		'{ROW_REQ, '{REQ_ENQUEUE, 6'd9, 3'd0}, 4'd0, 1'b1, '{ST_BAD_QUEUE, 6'd0}},
		'{ROW_REQ, '{REQ_DEQUEUE, 6'd0, 3'd0}, 4'd0, 1'b1, '{ST_BAD_QUEUE, 6'd0}},
		'{ROW_REQ, '{REQ_REMOVE, 6'd21, 3'd5}, 4'd0, 1'b0, NO_RSP},
		'{ROW_CFG, NO_REQ, 4'd15, 1'b0, NO_RSP},
		'{ROW_REQ, '{REQ_ENQUEUE, 6'd8, 3'd7}, 4'd0, 1'b0, NO_RSP},
		'{ROW_REQ, '{REQ_DEQUEUE, 6'd0, 3'd0}, 4'd0, 1'b0, NO_RSP}
	};

	localparam logic [QIU_W-1:0] PHASE_LIMIT [5] = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd8};

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	req_t             req       = '0;
	logic             cfg_valid = 1'b0;
	logic [QIU_W-1:0] cfg_data  = '0;
	logic             busy;
	logic             done;
	rsp_t             result;
	logic             cfg_ready;

	// shadow copy of the link table
	logic [LINK_W-1:0] link_next [DEPTH];
	logic [LINK_W-1:0] link_prev [DEPTH];
	logic              item_held [NI];
	logic [QIU_W-1:0]  queue_limit;

	rsp_t expected_rsp_q [$];
	int   mismatch_count = 0;
	int   cycle_count    = 0;

	multi_queue_linked_fifo i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic void clear_links();
		for (int n = 0; n < DEPTH; n++) begin
			link_next[n] = '0;
			link_prev[n] = '0;
		end
		for (int n = 0; n < NI; n++)
			item_held[n] = 1'b0;
		for (int q = 0; q < NQ; q++) begin
			if (NI + 2 * q + 1 < DEPTH) begin
				link_next[NI + 2 * q]     = LINK_W'(NI + 2 * q + 1);
				link_prev[NI + 2 * q + 1] = LINK_W'(NI + 2 * q);
			end
		end
		queue_limit = QIU_RESET;
	endfunction

	function automatic bit queue_valid(int unsigned q);
		return q < queue_limit && q < NQ && NI + 2 * q + 1 < DEPTH;
	endfunction

	function automatic bit item_valid(int unsigned it);
		return it < NI && it < DEPTH;
	endfunction

	function automatic void unlink_node(int unsigned node);
		int unsigned nx;
		int unsigned pv;
		nx = link_next[node];
		pv = link_prev[node];
		if (nx < DEPTH && pv < DEPTH) begin
			link_next[pv] = LINK_W'(nx);
			link_prev[nx] = LINK_W'(pv);
		end
		link_next[node] = '0;
		link_prev[node] = '0;
	endfunction

	// applies one request to the shadow table and returns its response
	function automatic rsp_t apply_request(req_t r);
		rsp_t        o;
		int unsigned hd;
		int unsigned pv;
		int unsigned first;
		o = NO_RSP;
		hd = NI + 2 * r.queue_id;
		case (r.req_type)
			REQ_ENQUEUE: begin
				if (!queue_valid(r.queue_id)) begin
					o.status = ST_BAD_QUEUE;
				end else if (!item_valid(r.item_id) || item_held[r.item_id]) begin
					o.status = ST_BAD_ITEM;
				end else begin
					pv = link_prev[hd + 1];
					link_next[r.item_id] = LINK_W'(hd + 1);
					link_prev[r.item_id] = LINK_W'(pv);
					if (pv < DEPTH)
						link_next[pv] = LINK_W'(r.item_id);
					link_prev[hd + 1] = LINK_W'(r.item_id);
					item_held[r.item_id] = 1'b1;
					o.item_id_out = r.item_id;
				end
			end
			REQ_DEQUEUE: begin
				if (!queue_valid(r.queue_id)) begin
					o.status = ST_BAD_QUEUE;
				end else begin
					first = link_next[hd];
					if (first == hd + 1 || !item_valid(first)) begin
						o.status = ST_EMPTY;
					end else begin
						unlink_node(first);
						item_held[first] = 1'b0;
						o.item_id_out = ITEM_W'(first);
					end
				end
			end
			REQ_REMOVE: begin
				if (!item_valid(r.item_id)) begin
					o.status = ST_BAD_ITEM;
				end else if (!item_held[r.item_id]) begin
					o.status = ST_NOT_QUEUED;
				end else begin
					unlink_node(r.item_id);
					item_held[r.item_id] = 1'b0;
					o.item_id_out = r.item_id;
				end
			end
			default: begin
				o.status = ST_BAD_QUEUE;
			end
		endcase
		return o;
	endfunction

	// first item from a random point whose queued flag matches
	function automatic logic [ITEM_W-1:0] pick_item(bit want_held);
		int unsigned base;
		int unsigned idx;
		base = $urandom_range(0, NI - 1);
		for (int k = 0; k < NI; k++) begin
			idx = (base + k) % NI;
			if (item_held[idx] == want_held)
				return ITEM_W'(idx);
		end
		return ITEM_W'(base);
	endfunction

	function automatic logic [QUEUE_W-1:0] pick_queue();
		int unsigned top;
		top = (queue_limit > NQ) ? NQ : queue_limit;
		if (top == 0 || $urandom_range(0, 99) < 15)
			return QUEUE_W'($urandom_range(0, NQ - 1));
		return QUEUE_W'($urandom_range(0, top - 1));
	endfunction

	// mostly well-formed traffic, some stray items and unused codes
	function automatic req_t random_request();
		req_t        r;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		r.item_id  = ITEM_W'($urandom_range(0, NI - 1));
		r.queue_id = QUEUE_W'($urandom_range(0, NQ - 1));
		if (roll < 40) begin
			r.req_type = REQ_ENQUEUE;
			r.queue_id = pick_queue();
			if ($urandom_range(0, 4) != 0)
				r.item_id = pick_item(1'b0);
		end else if (roll < 70) begin
			r.req_type = REQ_DEQUEUE;
			r.queue_id = pick_queue();
		end else if (roll < 95) begin
			r.req_type = REQ_REMOVE;
			if ($urandom_range(0, 4) != 0)
				r.item_id = pick_item(1'b1);
		end else begin
			r.req_type = REQ_UNUSED;
		end
		return r;
	endfunction

	// present one item, optionally after a gap, and wait until it is taken
	task automatic issue_request(req_t r, rsp_t want, int unsigned gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		expected_rsp_q.push_back(want);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (expected_rsp_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_queue_limit(logic [QIU_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		queue_limit = value;
	endtask

	function automatic int unsigned random_gap(bit idle_on);
		if (idle_on && $urandom_range(0, 3) == 0)
			return $urandom_range(1, 17);
		return 0;
	endfunction

	// compare each result with the oldest expected one
	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && done) begin
			if (expected_rsp_q.size() == 0) begin
				$display("%0t: unexpected result status %0d item %0d", $realtime,
					result.status, result.item_id_out);
				mismatch_count++;
			end else begin
				want = expected_rsp_q.pop_front();
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $realtime,
						want.status, result.status);
					mismatch_count++;
				end
				if (result.item_id_out !== want.item_id_out) begin
					$display("%0t: item_id_out expected %0d actual %0d", $realtime,
						want.item_id_out, result.item_id_out);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : stimulus
		rsp_t want;
		req_t r;
		bit   idle_on;
		clear_links();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// init sweep of the link table
		do @(posedge clk); while (busy);

		// directed table
		for (int i = 0; i < $size(DIRECTED); i++) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				write_queue_limit(DIRECTED[i].cfg);
			end else begin
				want = apply_request(DIRECTED[i].rq);
				if (DIRECTED[i].fixed)
					want = DIRECTED[i].rsp;
				issue_request(DIRECTED[i].rq, want, random_gap(1'b1));
			end
		end

		// random phases, one queue limit each, last one without gaps
		idle_on = 1'b0;
		for (int ph = 0; ph < $size(PHASE_LIMIT); ph++) begin
			write_queue_limit(PHASE_LIMIT[ph]);
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (n % 40 == 0)
					idle_on = (ph != $size(PHASE_LIMIT) - 1) && ($urandom_range(0, 2) != 0);
				r = random_request();
				want = apply_request(r);
				issue_request(r, want, random_gap(idle_on));
			end
		end

		wait_idle();
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
